@@ src/pps_pkg.sv @@
// Shared types, constants and helpers for the preemptive priority scheduler.
package pps_pkg;

    localparam int TIME_W = 16;
    localparam int SUM_W  = 20;
    localparam int PRIO_W = 8;
    localparam int PID_W  = 5;
    localparam int SUMX_W = SUM_W + 1;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam logic [SUM_W-1:0]  SUM_MAX  = '1;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [TIME_W-1:0] arrival_time;
        logic [TIME_W-1:0] burst_length;
        logic [PRIO_W-1:0] priority_level;
    } t_in_req;

    typedef struct packed {
        logic              ran;
        logic [PID_W-1:0]  process_id;
        logic              finished;
        logic [TIME_W-1:0] completion_time;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
        logic [TIME_W-1:0] response;
        logic [TIME_W-1:0] time_now;
        logic              all_done;
        logic [SUM_W-1:0]  total_turnaround;
        logic [SUM_W-1:0]  total_waiting;
        logic [SUM_W-1:0]  total_response;
    } t_out_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PICK,
        S_EXEC,
        S_TOTAL,
        S_POST
    } t_state;

    typedef struct packed {
        logic load;
        logic tick;
        logic scan;
        logic exec;
        logic total;
        logic post;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic scan_last;
        logic out_free;
    } t_dp_status;

    // Saturating accumulate of a time value into a running total.
    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
        logic [SUMX_W-1:0] s;
        s = {1'b0, a} + SUMX_W'(b);
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

endpackage

@@ src/preemptive_priority_scheduler.sv @@
// Top level of the preemptive priority scheduler: controller plus datapath.
//
// A load request appends a process (arrival, burst, priority) to a table of
// MAX_PROCESSES entries held in a memory with one write and one read port; ids
// follow load order from 1, a load into a full table is dropped, and a zero
// burst is stored as one. A load returns nothing. A tick request scans the
// loaded entries, one memory read per cycle, keeping the arrived, unfinished
// process with the highest priority (ties: earlier arrival, then lower id), runs
// it one unit, writes it back and returns one result request with its completion
// figures and the saturating totals. A tick steps through scan, pick, execute,
// totals and hand-off (an empty table skips scan and pick); the length of the
// scan is set by the one read port. The result sits in an output register; new
// requests are taken while it waits, and a later tick only stalls at its
// hand-off stage if the previous result has not been taken yet.
module preemptive_priority_scheduler #(
    parameter int MAX_PROCESSES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pps_pkg::t_in_req  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output pps_pkg::t_out_req o_out_data
);
    import pps_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    // Sequencer: owns the request handshake and steps the datapath.
    pps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_in_data.kind),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // Datapath: process table, winner search, clock, totals, result register.
    pps_dp #(
        .MAX_PROCESSES (MAX_PROCESSES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // A result only appears through the hand-off step.
    a_out_from_post: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(cmd.post))
        else $error("result appeared without hand-off");

    // An accepted tick blocks further requests until it completes.
    a_tick_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_data.kind == KIND_TICK) |=> !o_in_ready)
        else $error("request taken while a tick is in progress");

    // The hand-off step always leaves a valid result behind.
    a_post_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.post |=> o_out_valid)
        else $error("hand-off did not register a result");

endmodule

@@ src/pps_ctrl.sv @@
// Sequencer for the scheduler: load, scan, execute, totals and result hand-off.
module pps_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_kind,
    input  pps_pkg::t_dp_status i_status,
    output logic               o_in_ready,
    output pps_pkg::t_dp_cmd   o_cmd
);
    import pps_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_kind == KIND_TICK) begin
                    n_state = i_status.empty ? S_EXEC : S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_status.scan_last) begin
                    n_state = S_PICK;
                end
            end
            S_PICK:  n_state = S_EXEC;
            S_EXEC:  n_state = S_TOTAL;
            S_TOTAL: n_state = S_POST;
            S_POST: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid && i_kind == KIND_LOAD;
                o_cmd.tick = i_in_valid && i_kind == KIND_TICK;
            end
            S_SCAN:  o_cmd.scan  = 1'b1;
            S_PICK:  o_cmd       = '0;
            S_EXEC:  o_cmd.exec  = 1'b1;
            S_TOTAL: o_cmd.total = 1'b1;
            S_POST:  o_cmd.post  = i_status.out_free;
            default: o_cmd       = '0;
        endcase
    end

endmodule

@@ src/pps_dp.sv @@
// Scheduler datapath: process table memory, winner search, time and totals.
module pps_dp #(
    parameter int MAX_PROCESSES = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pps_pkg::t_dp_cmd    i_cmd,
    input  pps_pkg::t_in_req    i_in_data,
    output pps_pkg::t_dp_status o_status,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pps_pkg::t_out_req   o_out_data
);
    import pps_pkg::*;

    localparam int IW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int CW = $clog2(MAX_PROCESSES + 1);
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_PROCESSES);

    typedef struct packed {
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
        logic [PRIO_W-1:0] prio;
        logic [TIME_W-1:0] remaining;
        logic [TIME_W-1:0] start;
        logic              done;
    } t_row;

    t_row mem [MAX_PROCESSES];

    logic [CW-1:0]     r_loaded;
    logic [CW-1:0]     r_fin_count;
    logic [TIME_W-1:0] r_time;
    logic [SUM_W-1:0]  r_sum_tat;
    logic [SUM_W-1:0]  r_sum_wt;
    logic [SUM_W-1:0]  r_sum_rt;

    logic [IW-1:0]     r_scan_idx;
    logic              r_rd_valid;
    logic [IW-1:0]     r_rd_idx;
    t_row              r_rd_row;
    logic              r_best_valid;
    logic [IW-1:0]     r_best_idx;
    t_row              r_best_row;

    logic              r_ran;
    logic              r_fin;
    logic [PID_W-1:0]  r_pid;
    logic [TIME_W-1:0] r_ct;
    logic [TIME_W-1:0] r_tat;
    logic [TIME_W-1:0] r_rt;
    logic [TIME_W-1:0] r_burst;
    logic [TIME_W-1:0] r_wt;

    logic              r_out_valid;
    t_out_req          r_out;

    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    t_row              wr_row;
    t_row              load_row;
    t_row              exec_row;
    logic [TIME_W-1:0] load_burst;
    logic [TIME_W-1:0] n_time;
    logic [TIME_W-1:0] n_start;
    logic [TIME_W-1:0] n_remaining;
    logic              exec_fin;
    logic              elig;
    logic              better;
    logic [CW-1:0]     pid_full;
    logic [SUM_W-1:0]  n_sum_wt;
    logic              full;

    assign full = (r_loaded == COUNT_MAX);

    // Table write port: loads append, execute writes the winner back.
    always_comb begin
        load_burst         = (i_in_data.burst_length == '0) ? TIME_W'(1)
                                                            : i_in_data.burst_length;
        load_row.arrival   = i_in_data.arrival_time;
        load_row.burst     = load_burst;
        load_row.prio      = i_in_data.priority_level;
        load_row.remaining = load_burst;
        load_row.start     = '0;
        load_row.done      = 1'b0;

        n_start     = (r_best_row.remaining == r_best_row.burst) ? r_time : r_best_row.start;
        n_remaining = r_best_row.remaining - TIME_W'(1);
        exec_fin    = (n_remaining == '0);

        exec_row           = r_best_row;
        exec_row.start     = n_start;
        exec_row.remaining = n_remaining;
        exec_row.done      = exec_fin;

        wr_en   = 1'b0;
        wr_addr = r_best_idx;
        wr_row  = exec_row;
        if (i_cmd.load && !full) begin
            wr_en   = 1'b1;
            wr_addr = r_loaded[IW-1:0];
            wr_row  = load_row;
        end else if (i_cmd.exec && r_best_valid) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_row;
        end
        r_rd_row <= mem[r_scan_idx];
        r_rd_idx <= r_scan_idx;
    end

    // Winner search: higher priority, then earlier arrival; scan order breaks ties by id.
    assign elig   = r_rd_valid && !r_rd_row.done && (r_rd_row.arrival <= r_time);
    assign better = !r_best_valid
                 || (r_rd_row.prio > r_best_row.prio)
                 || (r_rd_row.prio == r_best_row.prio && r_rd_row.arrival < r_best_row.arrival);

    assign n_time   = (r_time != TIME_MAX) ? r_time + TIME_W'(1) : r_time;
    assign pid_full = CW'(r_best_idx) + CW'(1);
    assign n_sum_wt = sat_add(r_sum_wt, r_wt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded     <= '0;
            r_fin_count  <= '0;
            r_time       <= '0;
            r_sum_tat    <= '0;
            r_sum_wt     <= '0;
            r_sum_rt     <= '0;
            r_rd_valid   <= 1'b0;
            r_best_valid <= 1'b0;
            r_scan_idx   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_rd_valid <= i_cmd.scan;

            if (i_cmd.load && !full) begin
                r_loaded <= r_loaded + CW'(1);
            end

            if (i_cmd.tick) begin
                r_scan_idx   <= '0;
                r_best_valid <= 1'b0;
            end else if (i_cmd.scan) begin
                r_scan_idx <= r_scan_idx + IW'(1);
            end

            if (elig && better) begin
                r_best_valid <= 1'b1;
            end

            if (i_cmd.exec) begin
                r_time <= n_time;
                if (r_best_valid && exec_fin) begin
                    r_fin_count <= r_fin_count + CW'(1);
                end
            end

            if (i_cmd.total) begin
                r_sum_tat <= sat_add(r_sum_tat, r_tat);
                r_sum_rt  <= sat_add(r_sum_rt, r_rt);
            end

            if (i_cmd.post) begin
                r_sum_wt    <= n_sum_wt;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (elig && better) begin
            r_best_idx <= r_rd_idx;
            r_best_row <= r_rd_row;
        end

        if (i_cmd.exec) begin
            r_burst <= r_best_row.burst;
            if (r_best_valid) begin
                r_ran <= 1'b1;
                r_pid <= PID_W'(pid_full);
                r_fin <= exec_fin;
            end else begin
                r_ran <= 1'b0;
                r_pid <= '0;
                r_fin <= 1'b0;
            end
            if (r_best_valid && exec_fin) begin
                r_ct  <= n_time;
                r_tat <= n_time - r_best_row.arrival;
                r_rt  <= n_start - r_best_row.arrival;
            end else begin
                r_ct  <= '0;
                r_tat <= '0;
                r_rt  <= '0;
            end
        end

        if (i_cmd.total) begin
            r_wt <= (r_fin && r_tat >= r_burst) ? r_tat - r_burst : '0;
        end

        if (i_cmd.post) begin
            r_out.ran              <= r_ran;
            r_out.process_id       <= r_pid;
            r_out.finished         <= r_fin;
            r_out.completion_time  <= r_ct;
            r_out.turnaround       <= r_tat;
            r_out.waiting          <= r_wt;
            r_out.response         <= r_rt;
            r_out.time_now         <= r_time;
            r_out.all_done         <= (r_fin_count == r_loaded);
            r_out.total_turnaround <= r_sum_tat;
            r_out.total_waiting    <= n_sum_wt;
            r_out.total_response   <= r_sum_rt;
        end
    end

    assign o_status.empty     = (r_loaded == '0);
    assign o_status.scan_last = ((CW'(r_scan_idx) + CW'(1)) == r_loaded);
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
